// ===== sv/sha1_byte_stream_hash_macros.svh =====
// ----------------------------------------------------------------------------
// SHA-1 byte stream hash: assertion macros
// Shared property wrappers, sampled on clock and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef SHA1_BYTE_STREAM_HASH_MACROS_SVH
`define SHA1_BYTE_STREAM_HASH_MACROS_SVH

// same-cycle implication
`define SHA1BS_ASSERT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define SHA1BS_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== sv/sha1bs_pkg.sv =====
// ----------------------------------------------------------------------------
// SHA-1 byte stream hash: package
// Shared types, round constants and round helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package sha1bs_pkg;

   localparam logic [31:0] SHA1_H0 = 32'h6745_2301;
   localparam logic [31:0] SHA1_H1 = 32'hEFCD_AB89;
   localparam logic [31:0] SHA1_H2 = 32'h98BA_DCFE;
   localparam logic [31:0] SHA1_H3 = 32'h1032_5476;
   localparam logic [31:0] SHA1_H4 = 32'hC3D2_E1F0;

   localparam logic [31:0] SHA1_K0 = 32'h5A82_7999;
   localparam logic [31:0] SHA1_K1 = 32'h6ED9_EBA1;
   localparam logic [31:0] SHA1_K2 = 32'h8F1B_BCDC;
   localparam logic [31:0] SHA1_K3 = 32'hCA62_C1D6;

   localparam logic [6:0] ROUND_K1_START = 7'd20;
   localparam logic [6:0] ROUND_K2_START = 7'd40;
   localparam logic [6:0] ROUND_K3_START = 7'd60;
   localparam logic [6:0] ROUND_LAST     = 7'd79;

   localparam logic [3:0] WORD_LEN_HI = 4'd14;   // length word, high half
   localparam logic [3:0] WORD_LEN_LO = 4'd15;   // length word, low half, last of block

   localparam logic [1:0] BYTE_POS_LAST = 2'd3;

   localparam logic [31:0] PAD_WORD_FULL = 32'h8000_0000;  // 0x80 opening a word
   localparam logic [31:0] PAD_WORD_ONE  = 32'h0080_0000;  // 0x80 after one data byte

   // one packed message word as handed from front to back
   typedef struct packed {
      logic [31:0] word;    // big-endian, unused low bytes zero
      logic [1:0]  nb_m1;   // data bytes in word, minus one
      logic        last;    // holds the final message byte
   } word_entry_type;

   typedef struct packed {
      logic full;
      logic not_empty;
   } queue_status_type;

   typedef struct packed {
      logic        valid;
      logic [31:0] w4;
      logic [31:0] w3;
      logic [31:0] w2;
      logic [31:0] w1;
      logic [31:0] w0;
   } digest_type;

   typedef enum logic [1:0] {
      ST_LOAD,
      ST_PAD,
      ST_ROUND,
      ST_FINAL
   } core_state_type;

   function automatic logic [31:0] sha1bs_f(input logic [6:0] rnd, input logic [31:0] b,
                                           input logic [31:0] c, input logic [31:0] d);
      logic [31:0] f;
      priority if (rnd < ROUND_K1_START) begin
         f = (b & c) | (~b & d);
      end else if (rnd < ROUND_K2_START) begin
         f = b ^ c ^ d;
      end else if (rnd < ROUND_K3_START) begin
         f = (b & c) | (b & d) | (c & d);
      end else begin
         f = b ^ c ^ d;
      end
      return f;
   endfunction

   function automatic logic [31:0] sha1bs_k(input logic [6:0] rnd);
      logic [31:0] k;
      priority if (rnd < ROUND_K1_START) begin
         k = SHA1_K0;
      end else if (rnd < ROUND_K2_START) begin
         k = SHA1_K1;
      end else if (rnd < ROUND_K3_START) begin
         k = SHA1_K2;
      end else begin
         k = SHA1_K3;
      end
      return k;
   endfunction

endpackage

`default_nettype wire

// ===== sv/sha1bs_front.sv =====
// ----------------------------------------------------------------------------
// SHA-1 byte stream hash: front end
// Takes byte beats and packs them big-endian into words for the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module sha1bs_front import sha1bs_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           req_tvalid,
   output logic           req_tready,
   input  logic [7:0]     req_tdata,
   input  logic           req_tlast,
   input  logic           q_full,
   output logic           push,
   output word_entry_type push_entry
);

   logic [31:0] acc_ff, acc_in;
   logic [1:0]  bpos_ff, bpos_in;
   logic [31:0] merged;
   logic        accept;

   assign req_tready = !q_full;
   assign accept     = req_tvalid && req_tready;

   // byte 0 lands in the top byte of the word
   assign merged = acc_ff | ({24'd0, req_tdata} << {~bpos_ff, 3'b000});
   assign push   = accept && ((bpos_ff == BYTE_POS_LAST) || req_tlast);

   assign push_entry.word  = merged;
   assign push_entry.nb_m1 = bpos_ff;
   assign push_entry.last  = req_tlast;

   always_comb begin
      acc_in  = acc_ff;
      bpos_in = bpos_ff;
      if (push) begin
         acc_in  = '0;
         bpos_in = '0;
      end else if (accept) begin
         acc_in  = merged;
         bpos_in = bpos_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff  <= '0;
         bpos_ff <= '0;
      end else begin
         acc_ff  <= acc_in;
         bpos_ff <= bpos_in;
      end
   end

endmodule

`default_nettype wire

// ===== sv/sha1bs_queue.sv =====
// ----------------------------------------------------------------------------
// SHA-1 byte stream hash: word queue
// Small FIFO between the packing front end and the compression back end.
// ----------------------------------------------------------------------------
`default_nettype none

`include "sha1_byte_stream_hash_macros.svh"

module sha1bs_queue import sha1bs_pkg::*; #(
   parameter int DEPTH = 4   // 2 or more
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  word_entry_type   push_entry,
   input  logic             pop,
   output word_entry_type   head,
   output queue_status_type status
);

   localparam int PW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   word_entry_type  mem_ff [DEPTH];
   logic [PW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]   count_ff, count_in;

   assign head             = mem_ff[rd_ptr_ff];
   assign status.full      = (count_ff == CW'(DEPTH));
   assign status.not_empty = (count_ff != '0);

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

   `SHA1BS_ASSERT(a_no_push_full, push, !status.full || pop, "push into full queue")
   `SHA1BS_ASSERT(a_no_pop_empty, pop, status.not_empty, "pop from empty queue")
   `SHA1BS_ASSERT_NEXT(a_push_fills, push, count_ff != '0, "queue empty after push")

endmodule

`default_nettype wire

// ===== sv/sha1bs_core.sv =====
// ----------------------------------------------------------------------------
// SHA-1 byte stream hash: compression back end
// Loads words, appends padding and length, runs 80 rounds per block.
// ----------------------------------------------------------------------------
`default_nettype none

`include "sha1_byte_stream_hash_macros.svh"

module sha1bs_core import sha1bs_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  word_entry_type q_head,
   input  logic           q_valid,
   output logic           q_pop,
   input  logic           out_free,
   output digest_type     digest
);

   core_state_type state_ff, state_in;
   logic [3:0]     wcnt_ff, wcnt_in;
   logic [6:0]     rnd_ff, rnd_in;
   logic [60:0]    bcnt_ff, bcnt_in;
   logic           msg_end_ff, msg_end_in;   // last byte taken, padding under way
   logic           need80_ff, need80_in;     // 0x80 still to place
   logic           len_ok_ff, len_ok_in;     // length fits in this block
   logic           len_done_ff, len_done_in; // length is in this block

   logic [31:0] h_ff [5];
   logic [31:0] h_in [5];
   logic [31:0] a_ff, b_ff, c_ff, d_ff, e_ff;
   logic [31:0] a_in, b_in, c_in, d_in, e_in;
   logic [31:0] win_ff [16];   // schedule window, win_ff[0] is W[t]
   logic [31:0] win_in [16];

   logic [31:0] sum [5];
   logic [31:0] w_new;
   logic [31:0] t_val;
   logic [31:0] word;
   logic        load_word;
   logic [63:0] len_bits;

   assign sum[0] = h_ff[0] + a_ff;
   assign sum[1] = h_ff[1] + b_ff;
   assign sum[2] = h_ff[2] + c_ff;
   assign sum[3] = h_ff[3] + d_ff;
   assign sum[4] = h_ff[4] + e_ff;

   assign len_bits = {bcnt_ff, 3'b000};

   assign w_new = win_ff[13] ^ win_ff[8] ^ win_ff[2] ^ win_ff[0];
   assign t_val = {a_ff[26:0], a_ff[31:27]} + sha1bs_f(rnd_ff, b_ff, c_ff, d_ff) + e_ff
                + win_ff[0] + sha1bs_k(rnd_ff);

   always_comb begin
      state_in     = state_ff;
      wcnt_in      = wcnt_ff;
      rnd_in       = rnd_ff;
      bcnt_in      = bcnt_ff;
      msg_end_in   = msg_end_ff;
      need80_in    = need80_ff;
      len_ok_in    = len_ok_ff;
      len_done_in  = len_done_ff;
      h_in         = h_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      c_in         = c_ff;
      d_in         = d_ff;
      e_in         = e_ff;
      win_in       = win_ff;
      q_pop        = 1'b0;
      digest.valid = 1'b0;
      digest.w0    = sum[0];
      digest.w1    = sum[1];
      digest.w2    = sum[2];
      digest.w3    = sum[3];
      digest.w4    = sum[4];
      load_word    = 1'b0;
      word         = '0;

      unique case (state_ff)
         ST_LOAD: begin
            if (q_valid) begin
               q_pop     = 1'b1;
               load_word = 1'b1;
               word      = q_head.word;
               bcnt_in   = bcnt_ff + 61'(q_head.nb_m1) + 61'd1;
               if (q_head.last) begin
                  msg_end_in = 1'b1;
                  if (q_head.nb_m1 == BYTE_POS_LAST) begin
                     need80_in = 1'b1;
                  end else begin
                     word      = word | (PAD_WORD_ONE >> {q_head.nb_m1, 3'b000});
                     len_ok_in = (wcnt_ff < WORD_LEN_HI);
                  end
               end
            end
         end
         ST_PAD: begin
            load_word = 1'b1;
            if (need80_ff) begin
               word      = PAD_WORD_FULL;
               need80_in = 1'b0;
               len_ok_in = (wcnt_ff < WORD_LEN_HI);
            end else if (len_ok_ff && (wcnt_ff == WORD_LEN_HI)) begin
               word = len_bits[63:32];
            end else if (len_ok_ff && (wcnt_ff == WORD_LEN_LO)) begin
               word        = len_bits[31:0];
               len_done_in = 1'b1;
            end else begin
               word = '0;
            end
         end
         ST_ROUND: begin
            for (int i = 0; i < 15; i++) begin
               win_in[i] = win_ff[i+1];
            end
            win_in[15] = {w_new[30:0], w_new[31]};
            a_in   = t_val;
            b_in   = a_ff;
            c_in   = {b_ff[1:0], b_ff[31:2]};
            d_in   = c_ff;
            e_in   = d_ff;
            rnd_in = rnd_ff + 7'd1;
            if (rnd_ff == ROUND_LAST) begin
               state_in = ST_FINAL;
            end
         end
         ST_FINAL: begin
            if (len_done_ff) begin
               // digest goes out, then back to a fresh message
               if (out_free) begin
                  digest.valid = 1'b1;
                  h_in[0]      = SHA1_H0;
                  h_in[1]      = SHA1_H1;
                  h_in[2]      = SHA1_H2;
                  h_in[3]      = SHA1_H3;
                  h_in[4]      = SHA1_H4;
                  bcnt_in      = '0;
                  msg_end_in   = 1'b0;
                  need80_in    = 1'b0;
                  len_ok_in    = 1'b0;
                  len_done_in  = 1'b0;
                  state_in     = ST_LOAD;
               end
            end else begin
               h_in      = sum;
               len_ok_in = msg_end_ff && !need80_ff;
               state_in  = msg_end_ff ? ST_PAD : ST_LOAD;
            end
         end
      endcase

      if (load_word) begin
         for (int i = 0; i < 15; i++) begin
            win_in[i] = win_ff[i+1];
         end
         win_in[15] = word;
         wcnt_in    = wcnt_ff + 4'd1;
         if (wcnt_ff == WORD_LEN_LO) begin
            state_in = ST_ROUND;
            rnd_in   = '0;
            a_in     = h_ff[0];
            b_in     = h_ff[1];
            c_in     = h_ff[2];
            d_in     = h_ff[3];
            e_in     = h_ff[4];
         end else if (msg_end_in) begin
            state_in = ST_PAD;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_LOAD;
         wcnt_ff     <= '0;
         rnd_ff      <= '0;
         bcnt_ff     <= '0;
         msg_end_ff  <= 1'b0;
         need80_ff   <= 1'b0;
         len_ok_ff   <= 1'b0;
         len_done_ff <= 1'b0;
         h_ff[0]     <= SHA1_H0;
         h_ff[1]     <= SHA1_H1;
         h_ff[2]     <= SHA1_H2;
         h_ff[3]     <= SHA1_H3;
         h_ff[4]     <= SHA1_H4;
      end else begin
         state_ff    <= state_in;
         wcnt_ff     <= wcnt_in;
         rnd_ff      <= rnd_in;
         bcnt_ff     <= bcnt_in;
         msg_end_ff  <= msg_end_in;
         need80_ff   <= need80_in;
         len_ok_ff   <= len_ok_in;
         len_done_ff <= len_done_in;
         h_ff        <= h_in;
      end
   end

   always_ff @(posedge clock) begin
      a_ff   <= a_in;
      b_ff   <= b_in;
      c_ff   <= c_in;
      d_ff   <= d_in;
      e_ff   <= e_in;
      win_ff <= win_in;
   end

   `SHA1BS_ASSERT(a_round_range, state_ff == ST_ROUND, rnd_ff <= ROUND_LAST, "round past 79")
   `SHA1BS_ASSERT(a_no_pop_in_pad, msg_end_ff, !q_pop, "queue popped while padding")
   `SHA1BS_ASSERT_NEXT(a_digest_clears, digest.valid, state_ff == ST_LOAD && ~|bcnt_ff, "no clear")

endmodule

`default_nettype wire

// ===== sv/sha1_byte_stream_hash.sv =====
// ----------------------------------------------------------------------------
// SHA-1 byte stream hash: top level
// SHA-1 digest of a byte stream, one message byte per beat, tlast on the end.
// ----------------------------------------------------------------------------
//
//   channel | dir | beat content
//   --------+-----+--------------------------------------------------------
//   req_*   | in  | tdata[7:0] data_byte, tlast is_last
//   rsp_*   | out | tdata[159:0] digest_word_0 (lowest) .. digest_word_4
//
// Bytes are taken one a cycle while the word queue has room. A 64-byte block
// is loaded as 16 words, then runs 80 rounds and one chaining update.
// After the pop of the last byte's word, padding and length follow, in a second
// block if the length spills; the rsp beat is registered from the digest.
// Synchronous active-high reset restores the initial hash values.
// A stalled rsp side holds the digest; the queue then fills and drops req_tready.
// ----------------------------------------------------------------------------
`default_nettype none

module sha1_byte_stream_hash import sha1bs_pkg::*; #(
   parameter int QUEUE_DEPTH = 4   // word queue entries, 2 or more
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [7:0]   req_tdata,    // [7:0] data_byte
   input  logic         req_tlast,    // is_last
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [159:0] rsp_tdata     // [31:0] digest_word_0 .. [159:128] digest_word_4
);

   logic             push;
   word_entry_type   push_entry;
   logic             pop;
   word_entry_type   head;
   queue_status_type q_status;
   digest_type       digest;
   logic             out_free;

   logic             rsp_tvalid_ff, rsp_tvalid_in;
   logic [159:0]     rsp_tdata_ff, rsp_tdata_in;

   sha1bs_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .q_full     (q_status.full),
      .push       (push),
      .push_entry (push_entry)
   );

   sha1bs_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head       (head),
      .status     (q_status)
   );

   sha1bs_core u_core (
      .clock    (clock),
      .reset    (reset),
      .q_head   (head),
      .q_valid  (q_status.not_empty),
      .q_pop    (pop),
      .out_free (out_free),
      .digest   (digest)
   );

   // output register: free when empty or being drained this cycle
   assign out_free = !rsp_tvalid_ff || rsp_tready;

   always_comb begin
      rsp_tvalid_in = rsp_tvalid_ff;
      rsp_tdata_in  = rsp_tdata_ff;
      if (digest.valid) begin
         rsp_tvalid_in = 1'b1;
         rsp_tdata_in  = {digest.w4, digest.w3, digest.w2, digest.w1, digest.w0};
      end else if (rsp_tready) begin
         rsp_tvalid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else begin
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_tdata_ff <= rsp_tdata_in;
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

endmodule

`default_nettype wire
